// File: rtl/hst_pkg.sv
// Shared types, codes and constants of the handle slot table.
package hst_pkg;

    localparam int SLOTS_DEF   = 32;
    localparam int RESERVED    = 3;
    localparam int FIFO_DEPTH  = 2;

    localparam int CMD_W       = 3;
    localparam int SLOT_W      = 10;
    localparam int HOST_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int FOUND_W     = 17;
    localparam int USERS_W     = 8;

    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 40;

    localparam logic [FOUND_W-1:0] NONE_HANDLE = 17'h1FFFF;
    localparam logic [USERS_W-1:0] USERS_MAX   = 8'hFF;

    localparam logic [CMD_W-1:0] CMD_OPEN   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ATTACH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DETACH = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [2:0] {
        OP_OPEN,
        OP_CLOSE,
        OP_LOOKUP,
        OP_ATTACH,
        OP_DETACH,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic              in_range;
        logic [HOST_W-1:0] host;
    } req_t;

endpackage

// File: rtl/hst_front.sv
// Front end: accepts commands from the input stream and classifies them.
module hst_front #(
    parameter int SLOTS = hst_pkg::SLOTS_DEF
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata fields from bit 0: cmd[2:0], slot[12:3], host_handle[28:13], zero fill
    input  logic [hst_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          push_valid,
    input  logic                          push_ready,
    output hst_pkg::req_t                 push_req
);
    import hst_pkg::*;

    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;

    assign cmd  = s_tdata[CMD_W-1:0];
    assign slot = s_tdata[CMD_W+SLOT_W-1:CMD_W];

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_req.slot     = slot;
        push_req.host     = s_tdata[CMD_W+SLOT_W+HOST_W-1:CMD_W+SLOT_W];
        push_req.in_range = ({1'b0, slot} < (SLOT_W+1)'(SLOTS));
        unique case (cmd)
            CMD_OPEN:   push_req.op = OP_OPEN;
            CMD_CLOSE:  push_req.op = OP_CLOSE;
            CMD_LOOKUP: push_req.op = OP_LOOKUP;
            CMD_ATTACH: push_req.op = OP_ATTACH;
            CMD_DETACH: push_req.op = OP_DETACH;
            default:    push_req.op = OP_BAD;
        endcase
    end

endmodule

// File: rtl/hst_fifo.sv
// Short command queue between the front end and the table engine.
module hst_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  hst_pkg::req_t  push_req,
    output logic           pop_valid,
    input  logic           pop_ready,
    output hst_pkg::req_t  pop_req
);
    import hst_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    req_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = entry_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_W'(FIFO_DEPTH-1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(FIFO_DEPTH-1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= push_req;
        end
    end

endmodule

// File: rtl/hst_back.sv
// Table engine: used map, host-handle memory, user count and output register.
module hst_back #(
    parameter int SLOTS = hst_pkg::SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  hst_pkg::req_t                 pop_req,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata fields from bit 0: status[1:0], granted_slot[11:2], found_handle[28:12],
    // is_open[29], user_count[37:30], zero fill
    output logic [hst_pkg::M_DATA_W-1:0]  m_tdata
);
    import hst_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic [SLOTS-1:0]    used_reg, used_next;
    logic [RESERVED-1:0] raw_reg, raw_next;     // reserved slot not yet given a handle
    logic [USERS_W-1:0]  users_reg, users_next;
    logic [HOST_W-1:0]   mem [SLOTS];
    logic [HOST_W-1:0]   rdata_reg;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   granted_reg, granted_next;
    logic                is_open_reg, is_open_next;
    logic                use_mem_reg, use_mem_next;

    logic                adv;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic [IDX_W-1:0]    sidx;
    logic                hit;
    logic                mem_we, mem_re;

    assign pop_ready = !m_valid_reg || m_tready;
    assign adv       = pop_valid && pop_ready;
    assign sidx      = pop_req.slot[IDX_W-1:0];
    assign hit       = pop_req.in_range && used_reg[sidx];

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        used_next    = used_reg;
        raw_next     = raw_reg;
        users_next   = users_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        is_open_next = is_open_reg;
        use_mem_next = use_mem_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (adv) begin
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            granted_next = '0;
            is_open_next = 1'b0;
            use_mem_next = 1'b0;
            unique case (pop_req.op)
                OP_OPEN: begin
                    if (free_found) begin
                        used_next[free_idx] = 1'b1;
                        mem_we              = 1'b1;
                        granted_next        = SLOT_W'(free_idx);
                        if (free_idx < IDX_W'(RESERVED)) begin
                            raw_next[free_idx[1:0]] = 1'b0;
                        end
                    end else begin
                        status_next = ST_FULL;
                    end
                end
                OP_CLOSE, OP_LOOKUP: begin
                    if (hit) begin
                        is_open_next = 1'b1;
                        use_mem_next = !((sidx < IDX_W'(RESERVED)) && raw_reg[sidx[1:0]]);
                        mem_re       = 1'b1;
                        if (pop_req.op == OP_CLOSE) begin
                            used_next[sidx] = 1'b0;
                            if (sidx < IDX_W'(RESERVED)) begin
                                raw_next[sidx[1:0]] = 1'b0;
                            end
                        end
                    end else begin
                        status_next = ST_BAD;
                    end
                end
                OP_ATTACH: begin
                    if (users_reg != USERS_MAX) begin
                        users_next = users_reg + 1'b1;
                    end
                end
                OP_DETACH: begin
                    if (users_reg != '0) begin
                        users_next = users_reg - 1'b1;
                    end
                end
                default: begin
                    status_next = ST_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= {{(SLOTS-RESERVED){1'b0}}, {RESERVED{1'b1}}};
            raw_reg     <= '1;
            users_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            raw_reg     <= raw_next;
            users_reg   <= users_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        granted_reg <= granted_next;
        is_open_reg <= is_open_next;
        use_mem_reg <= use_mem_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[free_idx] <= pop_req.host;
        end
        if (mem_re) begin
            rdata_reg <= mem[sidx];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, users_reg, is_open_reg,
                       use_mem_reg ? {1'b0, rdata_reg} : NONE_HANDLE,
                       granted_reg, status_reg};

    a_raw_implies_used: assert property (@(posedge aclk) disable iff (!aresetn)
        raw_reg[0] |-> used_reg[0])
        else $error("reserved slot lost its used bit while still unassigned");

    a_grant_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != ST_OK) |-> (granted_reg == '0 && !is_open_reg))
        else $error("failed command carries a grant or open flag");

    a_mem_only_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && use_mem_reg) |-> is_open_reg)
        else $error("stored handle returned for a slot that was not open");

    a_open_marks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && pop_req.op == OP_OPEN && free_found) |=> used_reg[$past(free_idx)])
        else $error("granted slot not marked used");

endmodule

// File: rtl/handle_slot_table.sv
// Handle slot table: maps small local slots to host handles, one result per command.
// A command waits in the queue, then the engine registers its result.
// One command per cycle unless m_tready stalls; a two-entry queue decouples front and back.
// The free-slot search is a priority encoder over the used map in the engine.
// Reset (synchronous, aresetn low): slots 0-2 used with no handle, user count zero.
// No clearing pass: the stored handle is returned only for slots given a handle.
module handle_slot_table #(
    parameter int SLOTS = hst_pkg::SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata fields from bit 0: cmd[2:0], slot[12:3], host_handle[28:13], zero fill
    input  logic [hst_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata fields from bit 0: status[1:0], granted_slot[11:2], found_handle[28:12],
    // is_open[29], user_count[37:30], zero fill
    output logic [hst_pkg::M_DATA_W-1:0]  m_tdata
);
    import hst_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    req_t push_req, pop_req;

    hst_front #(.SLOTS(SLOTS)) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    hst_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    hst_back #(.SLOTS(SLOTS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_req   (pop_req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
